// File: rtl/sfscp_pkg.sv
// ----------------------------------------------------------------------------
// sfscp_pkg
// Shared types and constants for the sensor frame sync/checksum parser.
// ----------------------------------------------------------------------------
package sfscp_pkg;

  localparam int FRAME_LEN  = 17;
  localparam int DATA_BYTES = FRAME_LEN - 2;  // frame bytes 1..15 held in storage

  localparam logic [7:0]  SYNC_BYTE_RST     = 8'h3C;
  localparam logic [7:0]  TYPE_BYTE_RST     = 8'h02;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd200;

  // Configuration register indexes.
  localparam logic [1:0] REG_SYNC_BYTE     = 2'd0;
  localparam logic [1:0] REG_TYPE_BYTE     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  // Input action codes.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_BAD_SUM  = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  sync_byte;
    logic [7:0]  type_byte;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic [15:0]        co2;
    logic [15:0]        formaldehyde;
    logic [15:0]        tvoc;
    logic [15:0]        pm_fine;
    logic [15:0]        pm_coarse;
    logic signed [7:0]  temp_whole;
    logic [7:0]         temp_fraction;
    logic [7:0]         humidity_whole;
    logic [7:0]         humidity_fraction;
  } result_t;

endpackage

// File: rtl/sfscp_core.sv
// ----------------------------------------------------------------------------
// sfscp_core
// Frame state machine: sync hunt, byte collection, tick timeout and the
// final type/checksum check with decode of the readings.
// ----------------------------------------------------------------------------
module sfscp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  sfscp_pkg::cfg_t   cfg,
  input  logic              step_valid,
  input  logic              step_action,
  input  logic [7:0]        step_byte,
  input  logic              step_en,
  output logic              res_valid,
  output sfscp_pkg::result_t res
);
  import sfscp_pkg::*;

  localparam int CNT_W = $clog2(FRAME_LEN);
  localparam int IDX_W = $clog2(DATA_BYTES);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_LEN - 1);

  logic              collecting_r, collecting_nxt;
  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic [7:0]        running_sum_r, running_sum_nxt;
  logic [15:0]       elapsed_ticks_r, elapsed_ticks_nxt;
  logic [7:0]        frame_bytes_r [DATA_BYTES];

  logic [16:0]       tick_next;
  logic              data_wr;
  logic [IDX_W-1:0]  wr_idx;
  logic [6:0]        temp_mag;

  assign tick_next = {1'b0, elapsed_ticks_r} + 17'd1;
  assign wr_idx    = IDX_W'(byte_count_r - CNT_W'(1));
  assign temp_mag  = frame_bytes_r[11][6:0];

  always_comb begin
    collecting_nxt    = collecting_r;
    byte_count_nxt    = byte_count_r;
    running_sum_nxt   = running_sum_r;
    elapsed_ticks_nxt = elapsed_ticks_r;
    data_wr           = 1'b0;
    res_valid         = 1'b0;
    res               = '0;
    res.status        = ST_OK;

    if (step_valid) begin
      if (step_action == ACT_TICK) begin
        if (collecting_r) begin
          if (tick_next >= {1'b0, cfg.timeout_ticks}) begin
            collecting_nxt    = 1'b0;
            byte_count_nxt    = '0;
            running_sum_nxt   = '0;
            elapsed_ticks_nxt = '0;
            res_valid         = 1'b1;
            res.status        = ST_TIMEOUT;
          end else begin
            elapsed_ticks_nxt = tick_next[15:0];
          end
        end
      end else if (!collecting_r) begin
        if (step_byte == cfg.sync_byte) begin
          collecting_nxt    = 1'b1;
          byte_count_nxt    = CNT_W'(1);
          running_sum_nxt   = step_byte;
          elapsed_ticks_nxt = '0;
        end
      end else if (byte_count_r < LAST_CNT) begin
        data_wr         = 1'b1;
        running_sum_nxt = running_sum_r + step_byte;
        byte_count_nxt  = byte_count_r + CNT_W'(1);
      end else begin
        // Checksum byte: the frame ends here whatever the outcome.
        collecting_nxt    = 1'b0;
        byte_count_nxt    = '0;
        running_sum_nxt   = '0;
        elapsed_ticks_nxt = '0;
        res_valid         = 1'b1;
        if (frame_bytes_r[0] != cfg.type_byte) begin
          res.status = ST_BAD_TYPE;
        end else if (running_sum_r != step_byte) begin
          res.status = ST_BAD_SUM;
        end else begin
          res.co2               = {frame_bytes_r[1], frame_bytes_r[2]};
          res.formaldehyde      = {frame_bytes_r[3], frame_bytes_r[4]};
          res.tvoc              = {frame_bytes_r[5], frame_bytes_r[6]};
          res.pm_fine           = {frame_bytes_r[7], frame_bytes_r[8]};
          res.pm_coarse         = {frame_bytes_r[9], frame_bytes_r[10]};
          // Sign-magnitude to two's complement; negative zero folds to zero.
          res.temp_whole        = frame_bytes_r[11][7] ? -$signed({1'b0, temp_mag})
                                                       : $signed({1'b0, temp_mag});
          res.temp_fraction     = frame_bytes_r[12];
          res.humidity_whole    = frame_bytes_r[13];
          res.humidity_fraction = frame_bytes_r[14];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r    <= 1'b0;
      byte_count_r    <= '0;
      running_sum_r   <= '0;
      elapsed_ticks_r <= '0;
    end else if (step_en) begin
      collecting_r    <= collecting_nxt;
      byte_count_r    <= byte_count_nxt;
      running_sum_r   <= running_sum_nxt;
      elapsed_ticks_r <= elapsed_ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && data_wr) begin
      frame_bytes_r[wr_idx] <= step_byte;
    end
  end

  a_hunt_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !collecting_r |-> (byte_count_r == '0) && (elapsed_ticks_r == '0))
    else $error("byte count or tick count nonzero while hunting");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r |-> (byte_count_r != '0) && (byte_count_r <= LAST_CNT))
    else $error("byte count out of range while collecting");

  a_result_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res_valid) |=> !collecting_r)
    else $error("frame still open after a result");

endmodule

// File: rtl/sfscp_out_buf.sv
// ----------------------------------------------------------------------------
// sfscp_out_buf
// Result register with a skid entry, so the parser keeps running for one
// more result while the consumer stalls.
// ----------------------------------------------------------------------------
module sfscp_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  sfscp_pkg::result_t push_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sfscp_pkg::result_t out_data
);
  import sfscp_pkg::*;

  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  logic    pop, push;

  assign pop        = out_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign push       = push_valid && push_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty result register");

  a_skid_moves_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> out_valid_r && !skid_valid_r)
    else $error("skid entry not moved into result register");

  a_out_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_data_r))
    else $error("result changed or dropped while the consumer stalled");

endmodule

// File: rtl/sensor_frame_sync_checksum_parser_top.sv
// ----------------------------------------------------------------------------
// sensor_frame_sync_checksum_parser_top
// Serial sensor frame parser with sync hunt, tick timeout and sum check.
// ----------------------------------------------------------------------------
// Each request is one received byte or one time tick. The block accepts one
// request every clock cycle while the result path is not stalled; a request
// is registered, processed by the combinational frame state update, and any
// result it causes is registered in the output buffer that drives out_valid.
// A result register plus one skid entry absorb consumer stalls, so in_ready
// drops only once both hold undelivered results. Configuration writes are
// taken in any cycle (cfg_ready is always high) and are meant to be issued
// while the block is idle.
module sensor_frame_sync_checksum_parser_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [7:0]        in_rx_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [15:0]       out_co2,
  output logic [15:0]       out_formaldehyde,
  output logic [15:0]       out_tvoc,
  output logic [15:0]       out_pm_fine,
  output logic [15:0]       out_pm_coarse,
  output logic signed [7:0] out_temp_whole,
  output logic [7:0]        out_temp_fraction,
  output logic [7:0]        out_humidity_whole,
  output logic [7:0]        out_humidity_fraction
);
  import sfscp_pkg::*;

  cfg_t       cfg_r;
  logic       stage_valid_r;
  logic       stage_action_r;
  logic [7:0] stage_byte_r;
  logic       advance;
  logic       in_fire;
  logic       res_valid;
  result_t    res;
  logic       buf_ready;
  result_t    out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte     <= SYNC_BYTE_RST;
      cfg_r.type_byte     <= TYPE_BYTE_RST;
      cfg_r.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SYNC_BYTE:     cfg_r.sync_byte     <= cfg_data[7:0];
        REG_TYPE_BYTE:     cfg_r.type_byte     <= cfg_data[7:0];
        REG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // A request that causes no result never waits on the output side.
  assign advance  = stage_valid_r && (!res_valid || buf_ready);
  assign in_ready = !stage_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_fire) begin
      stage_valid_r <= 1'b1;
    end else if (advance) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_action_r <= in_action;
      stage_byte_r   <= in_rx_byte;
    end
  end

  sfscp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .step_valid  (stage_valid_r),
    .step_action (stage_action_r),
    .step_byte   (stage_byte_r),
    .step_en     (advance),
    .res_valid   (res_valid),
    .res         (res)
  );

  sfscp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (advance && res_valid),
    .push_ready (buf_ready),
    .push_data  (res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_status            = out_data.status;
  assign out_co2               = out_data.co2;
  assign out_formaldehyde      = out_data.formaldehyde;
  assign out_tvoc              = out_data.tvoc;
  assign out_pm_fine           = out_data.pm_fine;
  assign out_pm_coarse         = out_data.pm_coarse;
  assign out_temp_whole        = out_data.temp_whole;
  assign out_temp_fraction     = out_data.temp_fraction;
  assign out_humidity_whole    = out_data.humidity_whole;
  assign out_humidity_fraction = out_data.humidity_fraction;

endmodule
